### hw/rtl/pcx_rle_plane_decoder_defines.svh
// Assertion macros used by the decoder back end.
`ifndef PCX_RLE_PLANE_DECODER_DEFINES_SVH
`define PCX_RLE_PLANE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define PCXRLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcxrle assertion failed");
// Check cons in the cycle after ante holds.
`define PCXRLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcxrle assertion failed");
`else
`define PCXRLE_ASSERT_SAME(label, ante, cons)
`define PCXRLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/pcxrle_pkg.sv
package pcxrle_pkg;

	localparam int ADDR_WIDTH = 24;
	localparam int OUT_ADDR_W = 24;

	localparam logic [7:0] RUN_MARK       = 8'hC0;
	localparam logic [5:0] RUN_COUNT_MASK = 6'h3F;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BPL         = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT  = 2'd2;

	typedef enum logic {
		FS_CODE,
		FS_RUN_VALUE
	} front_state_t;

	// One expansion job: write value count times.
	typedef struct packed {
		logic [7:0] value;
		logic [5:0] count;
	} cmd_t;

endpackage

### hw/rtl/pcxrle_front.sv
module pcxrle_front
	import pcxrle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] code_byte,
	input  logic       blocked,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	front_state_t state_q, state_d;
	logic [5:0]   count_q, count_d;
	logic         take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_CODE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		q_push      = 1'b0;
		q_cmd.value = code_byte;
		q_cmd.count = 6'd1;
		case (state_q)
			FS_CODE: begin
				if (take) begin
					if ((code_byte & RUN_MARK) == RUN_MARK) begin
						state_d = FS_RUN_VALUE;
						count_d = code_byte[5:0] & RUN_COUNT_MASK;
					end else begin
						q_push = 1'b1;
					end
				end
			end
			FS_RUN_VALUE: begin
				if (take) begin
					state_d     = FS_CODE;
					count_d     = '0;
					q_cmd.count = count_q;
					// drop zero-length runs here
					q_push      = (count_q != 6'd0);
				end
			end
			default: begin
				state_d = FS_CODE;
			end
		endcase
	end

endmodule

### hw/rtl/pcxrle_fifo.sv
module pcxrle_fifo
	import pcxrle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/pcxrle_back.sv
`include "pcx_rle_plane_decoder_defines.svh"

module pcxrle_back
	import pcxrle_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   q_empty,
	input  cmd_t                   q_head,
	output logic                   q_pop,
	output logic                   blocked,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_ADDR_W-1:0]  out_address,
	output logic [7:0]             out_value,
	output logic                   last_of_run,
	output logic                   image_done
);

	logic [2:0]            plane_count_q;
	logic [13:0]           bpl_q;
	logic [15:0]           line_count_q;

	logic                  busy_q;
	logic [7:0]            cmd_value_q;
	logic [5:0]            cmd_left_q;

	logic [ADDR_WIDTH-1:0] write_address_q;
	logic [ADDR_WIDTH-1:0] scanline_start_q;
	logic [13:0]           bytes_left_q;
	logic [1:0]            cur_plane_q;
	logic [15:0]           lines_done_q;
	logic                  finished_q;

	logic                  out_valid_q;
	logic [OUT_ADDR_W-1:0] out_address_q;
	logic [7:0]            out_value_q;
	logic                  last_q;
	logic                  done_q;

	logic [2:0]            planes_eff;
	logic [13:0]           bpl_eff;
	logic [13:0]           cfg_bpl_eff;
	logic [2:0]            plane_next;
	logic [15:0]           lines_next;
	logic                  emit;
	logic                  drop;
	logic                  line_end;
	logic                  plane_end;
	logic                  img_end;
	logic                  last_res;
	logic [ADDR_WIDTH-1:0] addr_d;
	logic [ADDR_WIDTH-1:0] line_start_d;

	assign planes_eff  = (plane_count_q == 3'd0) ? 3'd1 :
		(plane_count_q > 3'd4) ? 3'd4 : plane_count_q;
	assign bpl_eff     = (bpl_q == '0) ? 14'd1 : bpl_q;
	assign cfg_bpl_eff = (cfg_data[13:0] == '0) ? 14'd1 : cfg_data[13:0];
	assign plane_next  = {1'b0, cur_plane_q} + 3'd1;
	assign lines_next  = lines_done_q + 16'd1;

	assign blocked = finished_q || (lines_done_q >= line_count_q);
	assign emit    = busy_q && !finished_q && (!out_valid_q || out_ready);
	assign drop    = busy_q && finished_q;
	assign q_pop   = !busy_q && !q_empty;

	assign plane_end    = (bytes_left_q <= 14'd1);
	assign line_end     = plane_end && !(plane_next < planes_eff);
	assign img_end      = line_end && (lines_next >= line_count_q);
	assign last_res     = (cmd_left_q == 6'd1) || line_end;
	assign line_start_d = write_address_q + ADDR_WIDTH'(1);

	always_comb begin
		if (!plane_end) begin
			addr_d = write_address_q + ADDR_WIDTH'(planes_eff);
		end else if (!line_end) begin
			addr_d = scanline_start_q + ADDR_WIDTH'(plane_next);
		end else begin
			addr_d = line_start_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q    <= 3'd1;
			bpl_q            <= 14'd1;
			line_count_q     <= 16'd1;
			busy_q           <= 1'b0;
			cmd_left_q       <= '0;
			write_address_q  <= '0;
			scanline_start_q <= '0;
			bytes_left_q     <= 14'd1;
			cur_plane_q      <= '0;
			lines_done_q     <= '0;
			finished_q       <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q     <= 1'b1;
				cmd_left_q <= q_head.count;
			end else if (drop || (emit && last_res)) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				cmd_left_q <= cmd_left_q - 6'd1;
			end

			if (emit) begin
				out_valid_q     <= 1'b1;
				write_address_q <= addr_d;
				if (!plane_end) begin
					bytes_left_q <= bytes_left_q - 14'd1;
				end else begin
					bytes_left_q <= bpl_eff;
					if (!line_end) begin
						cur_plane_q <= plane_next[1:0];
					end else begin
						cur_plane_q      <= '0;
						scanline_start_q <= line_start_d;
						lines_done_q     <= lines_next;
						if (img_end) begin
							finished_q <= 1'b1;
						end
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					CFG_PLANE_COUNT: plane_count_q <= cfg_data[2:0];
					CFG_BPL: begin
						bpl_q        <= cfg_data[13:0];
						bytes_left_q <= cfg_bpl_eff;
					end
					CFG_LINE_COUNT:  line_count_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_value_q <= q_head.value;
		end
		if (emit) begin
			out_address_q <= write_address_q[OUT_ADDR_W-1:0];
			out_value_q   <= cmd_value_q;
			last_q        <= last_res;
			done_q        <= img_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = out_address_q;
	assign out_value   = out_value_q;
	assign last_of_run = last_q;
	assign image_done  = done_q;

	`PCXRLE_ASSERT_SAME(a_done_is_last, out_valid_q && done_q, last_q)
	`PCXRLE_ASSERT_SAME(a_no_emit_after_done, finished_q, !emit)
	`PCXRLE_ASSERT_SAME(a_left_nonzero, busy_q, bytes_left_q != '0)
	`PCXRLE_ASSERT_NEXT(a_run_continues, emit && !last_res, busy_q && !finished_q)

endmodule

### hw/rtl/pcx_rle_plane_decoder.sv
// PCX RLE plane decoder. Feed it the coded pixel bytes of one image (header
// already stripped); each decoded byte comes out with its address in a
// plane-interleaved image. A byte with both top bits set is a run header with
// a 6-bit count and the next byte is the run value; any other byte is a
// literal. Runs that cross the end of a scanline are cut there. Output stops
// once line_count scanlines are written; image_done flags that last write and
// all later bytes are dropped until reset. The back end writes one result
// per cycle while out_ready does not stall it, and picks up each job from a
// four-entry queue only while it is idle. Header bytes and the value bytes
// of zero-length runs produce no result and cost one input transfer each.
// The config port is always ready; write it only while the decoder is idle.
module pcx_rle_plane_decoder
	import pcxrle_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             code_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_ADDR_W-1:0]  out_address,
	output logic [7:0]             out_value,
	output logic                   last_of_run,
	output logic                   image_done
);

	// Front end to queue.
	logic q_push;
	cmd_t q_cmd;
	logic q_full;

	// Queue to back end.
	logic q_pop;
	cmd_t q_head;
	logic q_empty;

	// Back end tells the front end to drop bytes once the image is done.
	logic blocked;

	assign cfg_ready = 1'b1;

	// Classify bytes: hold run headers, push literal and run jobs.
	pcxrle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_byte (code_byte),
		.blocked   (blocked),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	// Decouple classification from expansion.
	pcxrle_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head_cmd (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Expand jobs into addressed writes and advance the plane/line walk.
	pcxrle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.blocked     (blocked),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_address (out_address),
		.out_value   (out_value),
		.last_of_run (last_of_run),
		.image_done  (image_done)
	);

endmodule

### bench/pcx_decode_scoreboard_pkg.sv
`timescale 1ns / 1ps
package pcx_decode_scoreboard_pkg;
	import pcxrle_pkg::*;

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] address;
		logic [7:0]            value;
		logic                  last_of_run;
		logic                  image_done;
	} image_write_t;

	// Tracks decoder state and the image writes still owed by the DUT.
	class image_write_scoreboard;
		logic [2:0]            plane_reg;
		logic [13:0]           bpl_reg;
		logic [15:0]           line_reg;

		logic                  run_armed;
		logic [5:0]            run_length;
		logic [ADDR_WIDTH-1:0] write_addr;
		logic [13:0]           plane_bytes_left;
		logic [1:0]            plane_idx;
		logic [ADDR_WIDTH-1:0] line_base;
		logic                  image_finished;
		int unsigned           lines_written;

		image_write_t          expected_writes[$];
		int unsigned           mismatches;

		function new();
			plane_reg        = 3'd1;
			bpl_reg          = 14'd1;
			line_reg         = 16'd1;
			run_armed        = 1'b0;
			run_length       = '0;
			write_addr       = '0;
			plane_bytes_left = 14'd1;
			plane_idx        = '0;
			line_base        = '0;
			image_finished   = 1'b0;
			lines_written    = 0;
			mismatches       = 0;
		endfunction

		function int unsigned planes();
			if (plane_reg == 3'd0)
				return 1;
			if (plane_reg > 3'd4)
				return 4;
			return plane_reg;
		endfunction

		function logic [13:0] line_bytes();
			return (bpl_reg == 14'd0) ? 14'd1 : bpl_reg;
		endfunction

		function void apply_reg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
			CFG_PLANE_COUNT: plane_reg = data[2:0];
			CFG_BPL: begin
				bpl_reg          = data[13:0];
				plane_bytes_left = line_bytes();
			end
			CFG_LINE_COUNT: line_reg = data[15:0];
			default: ;
			endcase
		endfunction

		// Place one decoded byte; returns 0 once it closes the scanline.
		function bit place_byte(logic [7:0] value, output image_write_t w);
			int unsigned n;
			n             = planes();
			w.address     = write_addr[OUT_ADDR_W-1:0];
			w.value       = value;
			w.last_of_run = 1'b0;
			w.image_done  = 1'b0;
			write_addr    = write_addr + ADDR_WIDTH'(n);
			if (plane_bytes_left > 14'd1) begin
				plane_bytes_left--;
				return 1'b1;
			end
			plane_bytes_left = line_bytes();
			if (plane_idx + 1 < n) begin
				plane_idx++;
				write_addr = line_base + ADDR_WIDTH'(plane_idx);
				return 1'b1;
			end
			write_addr = write_addr - ADDR_WIDTH'(n - 1);
			line_base  = write_addr;
			plane_idx  = '0;
			lines_written++;
			if (lines_written >= line_reg) begin
				image_finished = 1'b1;
				w.image_done   = 1'b1;
			end
			return 1'b0;
		endfunction

		function void decode_code_byte(logic [7:0] code);
			image_write_t batch[$];
			image_write_t w;
			bit           more;
			if (image_finished || lines_written >= line_reg)
				return;
			if (run_armed) begin
				run_armed = 1'b0;
				for (int k = 0; k < run_length; k++) begin
					more = place_byte(code, w);
					batch.push_back(w);
					if (!more)
						break;
				end
				run_length = '0;
			end else if ((code & RUN_MARK) == RUN_MARK) begin
				run_armed  = 1'b1;
				run_length = code[5:0] & RUN_COUNT_MASK;
			end else begin
				void'(place_byte(code, w));
				batch.push_back(w);
			end
			if (batch.size() > 0) begin
				w             = batch.pop_back();
				w.last_of_run = 1'b1;
				batch.push_back(w);
			end
			foreach (batch[i])
				expected_writes.push_back(batch[i]);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_write(image_write_t got);
			image_write_t want;
			if (expected_writes.size() == 0) begin
				mismatches++;
				$display("%0t: write with none expected, actual addr 0x%0h value 0x%0h last %0b done %0b",
					$time, got.address, got.value, got.last_of_run, got.image_done);
				return;
			end
			want = expected_writes.pop_front();
			compare_field("out_address", want.address, got.address);
			compare_field("out_value", want.value, got.value);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
			compare_field("image_done", want.image_done, got.image_done);
		endfunction
	endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pcxrle_pkg::*;
	import pcx_decode_scoreboard_pkg::*;

	// Watchdog: far above the slowest legal run (every run at full length,
	// every result behind the heaviest output stall, every byte behind a gap).
	localparam int          CYCLE_LIMIT     = 1000000;
	// Quiet cycles after the last owed write before config writes or the end.
	localparam int          SETTLE_CYCLES   = 16;
	localparam int          ITEMS_PER_PHASE = 50;
	localparam int          RANDOM_PHASES   = 8;
	localparam logic [15:0] MAX_LINES       = 16'hFFFF;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_HEAVY
	} stall_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             code_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [OUT_ADDR_W-1:0]  out_address;
	logic [7:0]             out_value;
	logic                   last_of_run;
	logic                   image_done;

	image_write_scoreboard  image_writes = new();

	int unsigned            cycle_count;
	int unsigned            items_sent;
	int                     burst_left;
	stall_mode_t            stall_mode;
	int                     stall_left;
	int unsigned            stall_tick;

	pcx_rle_plane_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_address(out_address),
		.out_value(out_value),
		.last_of_run(last_of_run),
		.image_done(image_done)
	);

	always #1 clk = ~clk;

	// Output side: switch between free flow, coin-flip stalls and a heavy
	// pattern that raises out_ready only when stall_tick is a multiple of five.
	// Each mode holds for a random stretch so stalls land on every phase of a run.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
			stall_left = $urandom_range(4, 40);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
		STALL_NONE:   out_ready <= 1'b1;
		STALL_RANDOM: out_ready <= 1'($urandom_range(0, 1));
		default:      out_ready <= (stall_tick % 5 == 0);
		endcase
	end

	// Sample every channel at the rising edge. Check results before noting
	// the input of the same edge: that input cannot have produced them yet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				image_writes.check_write(image_write_t'{out_address, out_value, last_of_run,
					image_done});
			if (in_valid && in_ready)
				image_writes.decode_code_byte(code_byte);
			if (cfg_valid && cfg_ready)
				image_writes.apply_reg_write(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// All stimulus tasks start and return just after a falling edge, so the
	// monitor has already seen the last transfer when a task returns.

	// Present one code byte and hold it until the transfer. Bursts of random
	// length are broken by random gaps; some bursts follow with no gap at all.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		code_byte <= b;
		items_sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly well-formed items: a literal, or a run header with its value.
	// The rest is any byte at all, which also breaks up header/value pairs.
	task automatic send_random_item();
		int unsigned pick;
		logic [5:0]  count;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			send_byte(8'($urandom_range(0, 8'hBF)));
		end else if (pick < 90) begin
			pick  = $urandom_range(0, 19);
			count = (pick == 0) ? 6'd0 :
				(pick < 4) ? RUN_COUNT_MASK : 6'($urandom_range(1, 24));
			send_byte(RUN_MARK | {2'b00, count});
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Drop valid; the next byte starts a fresh burst.
	task automatic release_input();
		in_valid  <= 1'b0;
		burst_left = 0;
	endtask

	// Hold off until every owed write has arrived, then let the block settle.
	task automatic wait_drained();
		while (image_writes.expected_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int unsigned phase_start;
		bit          paused;
		logic [15:0] plane_data;
		logic [15:0] bpl_data;

		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_PLANE_COUNT;
		cfg_data    = '0;
		in_valid    = 1'b0;
		code_byte   = '0;
		out_ready   = 1'b0;
		cycle_count = 0;
		items_sent  = 0;
		burst_left  = 0;
		stall_mode  = STALL_NONE;
		stall_left  = 0;
		stall_tick  = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset leaves a one-line image: widen it before any data goes in.
		write_reg(CFG_LINE_COUNT, MAX_LINES);
		write_reg(CFG_PLANE_COUNT, 16'd1);
		write_reg(CFG_BPL, 16'd4);

		// Literal extremes, a one-byte run, a zero-length run that swallows
		// its value, a full 63-byte run cut at the end of the line, and run
		// values that look like headers.
		send_byte(8'h00); send_byte(8'hBF); send_byte(8'h7F); send_byte(8'h80);
		send_byte(8'hC1); send_byte(8'hFF);
		send_byte(8'hC0); send_byte(8'h55);
		send_byte(8'hFF); send_byte(8'hC3);
		send_byte(8'hC2); send_byte(8'hC0);
		release_input();
		wait_drained();

		// Out-of-range settings: plane count 7 acts as 4, zero line bytes as 1.
		// A run across four one-byte planes stops at the end of the scanline.
		write_reg(CFG_PLANE_COUNT, 16'hFFFF);
		write_reg(CFG_BPL, 16'hC000);
		send_byte(8'hC5); send_byte(8'h12);
		send_byte(8'h3C); send_byte(8'h01);
		release_input();
		wait_drained();

		// Park the address mid-way through plane 3, then cut the plane count
		// to zero (acts as 1): the plane line that ends next ends the scanline.
		write_reg(CFG_PLANE_COUNT, 16'd4);
		write_reg(CFG_BPL, 16'd3);
		send_byte(8'h10); send_byte(8'h20); send_byte(8'h30); send_byte(8'h40);
		send_byte(8'h50);
		release_input();
		wait_drained();
		write_reg(CFG_PLANE_COUNT, 16'h0008);
		send_byte(8'h05); send_byte(8'h0A); send_byte(8'h3F); send_byte(8'h40);
		release_input();
		wait_drained();

		// Line count already reached, then zero: bytes are dropped, headers too.
		write_reg(CFG_LINE_COUNT, 16'(image_writes.lines_written));
		send_byte(8'hC3); send_byte(8'h11);
		release_input();
		wait_drained();
		write_reg(CFG_LINE_COUNT, 16'd0);
		send_byte(8'h22);
		release_input();
		wait_drained();
		write_reg(CFG_LINE_COUNT, MAX_LINES);

		// Random phases, each under its own plane and line-length setting.
		// Most line lengths stay short so runs hit plane and line ends often.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			plane_data = (p == 0) ? 16'd1 : (p == 1) ? 16'd4 : 16'($urandom_range(0, 16'hFFFF));
			if (p == 2)
				bpl_data = 16'h3FFF;
			else if (p == 5)
				bpl_data = 16'hFFFF;
			else
				bpl_data = {2'($urandom_range(0, 3)), 14'($urandom_range(0, 12))};
			write_reg(CFG_PLANE_COUNT, plane_data);
			write_reg(CFG_BPL, bpl_data);
			phase_start = items_sent;
			paused      = 1'b0;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				send_random_item();
				// Halfway through, hold input until the output side catches up.
				if (!paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
					paused = 1'b1;
					release_input();
					wait_drained();
				end
			end
			release_input();
			wait_drained();
		end

		// Finish the image a few lines from here, then check that nothing
		// comes out afterwards, even once the line count is raised again.
		write_reg(CFG_LINE_COUNT, 16'(image_writes.lines_written + 3));
		write_reg(CFG_PLANE_COUNT, 16'd2);
		write_reg(CFG_BPL, 16'd2);
		while (!image_writes.image_finished)
			send_random_item();
		repeat (3) send_random_item();
		release_input();
		wait_drained();
		write_reg(CFG_LINE_COUNT, MAX_LINES);
		send_byte(8'h2A); send_byte(8'h3B);
		release_input();
		wait_drained();

		if (image_writes.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pcxrle_pkg.sv
hw/rtl/pcxrle_front.sv
hw/rtl/pcxrle_fifo.sv
hw/rtl/pcxrle_back.sv
hw/rtl/pcx_rle_plane_decoder.sv
bench/pcx_decode_scoreboard_pkg.sv
bench/tb_top.sv
